// File: rtl/igt_pkg.sv
// ----------------------------------------------------------------------------
// igt_pkg
// Shared types and constants for the integral gain tuner: word formats,
// configuration record, register indexes, controller states and commands.
// ----------------------------------------------------------------------------
`default_nettype none

package igt_pkg;

   // configuration register map
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 23;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KI_TEMP      = 3'd0,
      CSR_KI_HUMID     = 3'd1,
      CSR_LIMIT_TEMP   = 3'd2,
      CSR_LIMIT_HUMID  = 3'd3,
      CSR_DT_LIMIT     = 3'd4,
      CSR_GAIN_FLOOR   = 3'd5,
      CSR_GAIN_CEILING = 3'd6
   } csr_idx_type;

   // reset values
   localparam logic [15:0] KiTempRst      = 16'd6554;
   localparam logic [15:0] KiHumidRst     = 16'd3277;
   localparam logic [22:0] LimitTempRst   = 23'd983040;
   localparam logic [22:0] LimitHumidRst  = 23'd1966080;
   localparam logic [15:0] DtLimitRst     = 16'd2560;
   localparam logic [15:0] GainFloorRst   = 16'd8192;
   localparam logic [15:0] GainCeilingRst = 16'd40960;

   // 1.0 in Q2.14
   localparam logic signed [23:0] GainOne = 24'sd16384;

   // input command codes
   localparam logic CmdUpdate = 1'b0;
   localparam logic CmdClear  = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic signed [15:0] temp_error;
      logic              temp_valid;
      logic signed [15:0] humid_error;
      logic              humid_valid;
      logic [15:0]       step_time;
   } req_type;

   typedef struct packed {
      logic [15:0] gain_lamp;
      logic [15:0] gain_water;
      logic [15:0] gain_fog;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ki_temp;
      logic [15:0] ki_moist;
      logic [22:0] limit_temp;
      logic [22:0] limit_humid;
      logic [15:0] dt_limit;
      logic [15:0] gain_floor;
      logic [15:0] gain_ceiling;
   } cfg_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_T,
      ST_MUL_H,
      ST_KI_T,
      ST_KI_H,
      ST_TERM,
      ST_DONE
   } state_type;

   // shared multiplier operand select
   typedef enum logic [1:0] {
      MUL_ERR_T,
      MUL_ERR_H,
      MUL_KI_T,
      MUL_KI_H
   } mul_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        req_load;
      mul_sel_type mul_sel;
      logic        acc_t_step;
      logic        acc_h_step;
      logic        pt_load;
      logic        term_load;
      logic        out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/igt_csr.sv
// ----------------------------------------------------------------------------
// igt_csr
// Configuration registers: write-only, one register per index, unknown
// indexes ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module igt_csr
   import igt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_KI_TEMP:      cfg_in.ki_temp      = csr_wdata[15:0];
            CSR_KI_HUMID:     cfg_in.ki_moist     = csr_wdata[15:0];
            CSR_LIMIT_TEMP:   cfg_in.limit_temp   = csr_wdata;
            CSR_LIMIT_HUMID:  cfg_in.limit_humid  = csr_wdata;
            CSR_DT_LIMIT:     cfg_in.dt_limit     = csr_wdata[15:0];
            CSR_GAIN_FLOOR:   cfg_in.gain_floor   = csr_wdata[15:0];
            CSR_GAIN_CEILING: cfg_in.gain_ceiling = csr_wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ki_temp      <= KiTempRst;
         cfg_ff.ki_moist     <= KiHumidRst;
         cfg_ff.limit_temp   <= LimitTempRst;
         cfg_ff.limit_humid  <= LimitHumidRst;
         cfg_ff.dt_limit     <= DtLimitRst;
         cfg_ff.gain_floor   <= GainFloorRst;
         cfg_ff.gain_ceiling <= GainCeilingRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/igt_ctrl.sv
// ----------------------------------------------------------------------------
// igt_ctrl
// Sequencer: steps one word through the shared multiplier schedule and
// hands the finished gains to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module igt_ctrl
   import igt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MUL_T;
         ST_MUL_T: state_in = ST_MUL_H;
         ST_MUL_H: state_in = ST_KI_T;
         ST_KI_T:  state_in = ST_KI_H;
         ST_KI_H:  state_in = ST_TERM;
         ST_TERM:  state_in = ST_DONE;
         ST_DONE:  if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command decode
   always_comb begin
      cmd       = '0;
      cmd.mul_sel = MUL_ERR_T;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.req_load = req_valid;
         end
         ST_MUL_T: cmd.mul_sel = MUL_ERR_T;
         ST_MUL_H: begin
            cmd.mul_sel    = MUL_ERR_H;
            cmd.acc_t_step = 1'b1;
         end
         ST_KI_T: begin
            cmd.mul_sel    = MUL_KI_T;
            cmd.acc_h_step = 1'b1;
         end
         ST_KI_H: begin
            cmd.mul_sel = MUL_KI_H;
            cmd.pt_load = 1'b1;
         end
         ST_TERM: cmd.term_load = 1'b1;
         ST_DONE: cmd.out_load = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/igt_dp.sv
// ----------------------------------------------------------------------------
// igt_dp
// Datapath: input word register, one shared 25x17 signed multiplier with
// product register, two saturating integrators, gain terms and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module igt_dp
   import igt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_word,
   input  wire cfg_type cfg,
   input  wire cmd_type cmd,
   output status_type   status,
   input  wire logic    rsp_ready,
   output logic         rsp_valid,
   output rsp_type      rsp_word
);

   // add product, saturate at +/- limit
   function automatic logic signed [23:0] sat_add(input logic signed [23:0] acc,
                                                  input logic signed [39:0] p,
                                                  input logic [22:0] lim);
      logic signed [33:0] v;
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      v  = {{10{acc[23]}}, acc} + p[33:0];
      hi = {11'b0, lim};
      lo = -hi;
      if (v < lo) begin
         sat_add = lo[23:0];
      end else if (v > hi) begin
         sat_add = hi[23:0];
      end else begin
         sat_add = v[23:0];
      end
   endfunction

   // base plus term, clamped to floor then ceiling
   function automatic logic [15:0] clamp_gain(input logic signed [22:0] term,
                                              input logic [15:0] fl,
                                              input logic [15:0] ce);
      logic signed [23:0] g;
      logic signed [23:0] fl_s;
      logic signed [23:0] ce_s;
      g    = GainOne + {term[22], term};
      fl_s = {8'b0, fl};
      ce_s = {8'b0, ce};
      if (g < fl_s) begin
         clamp_gain = fl;
      end else if (g > ce_s) begin
         clamp_gain = ce;
      end else begin
         clamp_gain = g[15:0];
      end
   endfunction

   req_type            req_ff;
   logic signed [39:0] prod_ff, prod_in;
   logic signed [39:0] pt_ff;
   logic signed [23:0] temp_int_ff, temp_int_in;
   logic signed [23:0] humid_int_ff, humid_int_in;
   logic signed [22:0] term_l_ff, term_w_ff, term_m_ff;
   rsp_type            rsp_word_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [15:0]        dt;
   logic               do_int;
   logic signed [24:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [41:0] mul_p;
   logic signed [42:0] wsum;

   // effective time step
   assign dt     = (req_ff.step_time > cfg.dt_limit) ? cfg.dt_limit : req_ff.step_time;
   assign do_int = (req_ff.cmd == CmdUpdate) && (req_ff.step_time != 16'd0);

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR_T: begin
            mul_a = {{9{req_ff.temp_error[15]}}, req_ff.temp_error};
            mul_b = {1'b0, dt};
         end
         MUL_ERR_H: begin
            mul_a = {{9{req_ff.humid_error[15]}}, req_ff.humid_error};
            mul_b = {1'b0, dt};
         end
         MUL_KI_T: begin
            mul_a = {temp_int_ff[23], temp_int_ff};
            mul_b = {1'b0, cfg.ki_temp};
         end
         MUL_KI_H: begin
            mul_a = {humid_int_ff[23], humid_int_ff};
            mul_b = {1'b0, cfg.ki_moist};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = mul_p[39:0];

   // integrator updates
   always_comb begin
      temp_int_in  = temp_int_ff;
      humid_int_in = humid_int_ff;
      if (cmd.acc_t_step) begin
         if (req_ff.cmd == CmdClear) begin
            temp_int_in = '0;
         end else if (do_int && req_ff.temp_valid) begin
            temp_int_in = sat_add(temp_int_ff, prod_ff, cfg.limit_temp);
         end
      end
      if (cmd.acc_h_step) begin
         if (req_ff.cmd == CmdClear) begin
            humid_int_in = '0;
         end else if (do_int && req_ff.humid_valid) begin
            humid_int_in = sat_add(humid_int_ff, prod_ff, cfg.limit_humid);
         end
      end
   end

   // water term: 4*pt + ph, one floor shift
   assign wsum = {pt_ff[39], pt_ff, 2'b00} + {{3{prod_ff[39]}}, prod_ff};

   // output register handshake
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state and integrators
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_int_ff  <= '0;
         humid_int_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         temp_int_ff  <= temp_int_in;
         humid_int_ff <= humid_int_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_word;
      end
      prod_ff <= prod_in;
      if (cmd.pt_load) begin
         pt_ff <= prod_ff;
      end
      if (cmd.term_load) begin
         term_l_ff <= {pt_ff[39], pt_ff[39:18]};
         term_w_ff <= wsum[42:20];
         term_m_ff <= {prod_ff[39], prod_ff[39:18]};
      end
      if (cmd.out_load) begin
         rsp_word_ff.gain_lamp  <= clamp_gain(term_l_ff, cfg.gain_floor, cfg.gain_ceiling);
         rsp_word_ff.gain_water <= clamp_gain(term_w_ff, cfg.gain_floor, cfg.gain_ceiling);
         rsp_word_ff.gain_fog   <= clamp_gain(term_m_ff, cfg.gain_floor, cfg.gain_ceiling);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// File: rtl/integral_gain_tuner_top.sv
// ----------------------------------------------------------------------------
// integral_gain_tuner_top
// Integral controller with anti-windup clamp: turns temperature and humidity
// errors into lamp, water-heater and mist gains.
//
//   channel  ports                          direction  word
//   req      req_valid/req_ready/req_word   in         req_type
//   rsp      rsp_valid/rsp_ready/rsp_word   out        rsp_type
//   csr      csr_we/csr_index/csr_wdata     in         23-bit write data
//
// A word runs MUL_T, MUL_H, KI_T, KI_H, TERM, DONE from accept to rsp_valid;
// no new word is taken before it leaves DONE. The single shared multiplier
// is used four times per word (two error*dt products, two ki*integral terms).
// Reset is synchronous: integrators clear to zero, registers take defaults.
// A stalled result sits in the output register while the next word is
// accepted; the sequencer waits only if the register is still full when
// the next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module integral_gain_tuner_top
   import igt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_word,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_word,
   input  wire logic                csr_we,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   igt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   igt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   igt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// File: rtl/igt_checker.sv
// ----------------------------------------------------------------------------
// igt_checker
// Port-level checks for the integral gain tuner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module igt_checker
   import igt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_word
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result keeps its word
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("rsp_word changed while stalled");

   // one word at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after accept");

   // a new result comes out of the busy sequence
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while idle");

   // reset empties the output register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

endmodule

bind integral_gain_tuner_top igt_checker u_igt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

`default_nettype wire

// File: verif/gain_tuner_monitor.sv
// ----------------------------------------------------------------------------
// gain_tuner_monitor
// Watches the request, result and register ports of the integral gain tuner.
// It keeps its own copy of the registers and of both integrators, works out
// the three gains each accepted request word must produce, and compares
// every accepted result word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gain_tuner_monitor
   import igt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  req_type             req_word,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsp_type             rsp_word,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                  mismatches,
   output int                  outstanding,
   output int                  checked
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam cfg_type ResetCfg = '{
      ki_temp:      KiTempRst,
      ki_moist:     KiHumidRst,
      limit_temp:   LimitTempRst,
      limit_humid:  LimitHumidRst,
      dt_limit:     DtLimitRst,
      gain_floor:   GainFloorRst,
      gain_ceiling: GainCeilingRst
   };

   cfg_type            regs;
   logic signed [23:0] temp_sum;
   logic signed [23:0] humid_sum;
   rsp_type            gains_due [$];

   // add error * dt and saturate symmetrically at the limit
   function automatic logic signed [23:0] integrate_clamped(
      input logic signed [23:0] acc,
      input logic signed [15:0] err,
      input logic [15:0]        dt,
      input logic [22:0]        lim
   );
      longint sum;
      longint bound;
      sum   = longint'(acc) + longint'(err) * longint'(dt);
      bound = longint'(lim);
      if (sum > bound) begin
         sum = bound;
      end else if (sum < -bound) begin
         sum = -bound;
      end
      return sum[23:0];
   endfunction

   // base 1.0 plus the term, then floor first, ceiling second
   function automatic logic [15:0] clamp_gain(input longint term);
      longint g;
      g = longint'(GainOne) + term;
      if (g < longint'(regs.gain_floor)) return regs.gain_floor;
      if (g > longint'(regs.gain_ceiling)) return regs.gain_ceiling;
      return g[15:0];
   endfunction

   // advance both integrators for one word and return the gains it yields
   function automatic rsp_type next_gains(input req_type w);
      logic [15:0] dt;
      longint      pt;
      longint      ph;
      rsp_type     r;
      if (w.cmd == CmdClear) begin
         temp_sum  = '0;
         humid_sum = '0;
      end else if (w.step_time != 16'd0) begin
         dt = (w.step_time > regs.dt_limit) ? regs.dt_limit : w.step_time;
         if (w.temp_valid) begin
            temp_sum = integrate_clamped(temp_sum, w.temp_error, dt, regs.limit_temp);
         end
         if (w.humid_valid) begin
            humid_sum = integrate_clamped(humid_sum, w.humid_error, dt, regs.limit_humid);
         end
      end
      pt = longint'(regs.ki_temp) * longint'(temp_sum);
      ph = longint'(regs.ki_moist) * longint'(humid_sum);
      // shifts on signed values truncate toward minus infinity
      r.gain_lamp  = clamp_gain(pt >>> 18);
      r.gain_water = clamp_gain((pt * 4 + ph) >>> 20);
      r.gain_fog   = clamp_gain(ph >>> 18);
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // all port activity is sampled at the rising edge
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         regs      = ResetCfg;
         temp_sum  = '0;
         humid_sum = '0;
         gains_due.delete();
      end else begin
         // register writes; unknown indexes are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_KI_TEMP:      regs.ki_temp      = csr_wdata[15:0];
               CSR_KI_HUMID:     regs.ki_moist     = csr_wdata[15:0];
               CSR_LIMIT_TEMP:   regs.limit_temp   = csr_wdata[22:0];
               CSR_LIMIT_HUMID:  regs.limit_humid  = csr_wdata[22:0];
               CSR_DT_LIMIT:     regs.dt_limit     = csr_wdata[15:0];
               CSR_GAIN_FLOOR:   regs.gain_floor   = csr_wdata[15:0];
               CSR_GAIN_CEILING: regs.gain_ceiling = csr_wdata[15:0];
               default: ;
            endcase
         end
         // result words against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (gains_due.size() == 0) begin
               $error("unexpected result word: lamp %0d water %0d fog %0d",
                      rsp_word.gain_lamp, rsp_word.gain_water, rsp_word.gain_fog);
               mismatches++;
            end else begin
               want = gains_due.pop_front();
               compare_field("gain_lamp", want.gain_lamp, rsp_word.gain_lamp);
               compare_field("gain_water", want.gain_water, rsp_word.gain_water);
               compare_field("gain_fog", want.gain_fog, rsp_word.gain_fog);
               checked++;
            end
         end
         // every accepted request word yields exactly one result
         if (req_valid && req_ready) begin
            gains_due.push_back(next_gains(req_word));
         end
      end
      outstanding <= gains_due.size();
   end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the integral gain tuner. A directed opening hits
// saturation, zero steps, frozen channels, lowered limits, a zero dt limit
// and an inverted gain range; random phases under changing register settings
// and random idling on both channels follow. Checking lives in the monitor.
// ----------------------------------------------------------------------------
module testbench
   import igt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit    = 400000;
   localparam int SettleCycles  = 10;
   localparam int HoldCycles    = 200;
   localparam int RandomPhases  = 9;
   localparam int WordsPerPhase = 72;
   localparam int HoldPhase     = 3;

   localparam logic [CsrIdxW-1:0] CsrUnused = 3'd7;
   localparam logic signed [15:0] ErrMax    = 16'sh7FFF;
   localparam logic signed [15:0] ErrMin    = 16'sh8000;

   localparam cfg_type ResetCfg = '{
      ki_temp:      KiTempRst,
      ki_moist:     KiHumidRst,
      limit_temp:   LimitTempRst,
      limit_humid:  LimitHumidRst,
      dt_limit:     DtLimitRst,
      gain_floor:   GainFloorRst,
      gain_ceiling: GainCeilingRst
   };
   localparam cfg_type MaxCfg = '{
      ki_temp:      16'hFFFF,
      ki_moist:     16'hFFFF,
      limit_temp:   23'h7FFFFF,
      limit_humid:  23'h7FFFFF,
      dt_limit:     16'hFFFF,
      gain_floor:   16'h0000,
      gain_ceiling: 16'hFFFF
   };
   localparam cfg_type MinCfg = '{
      ki_temp:      16'h0000,
      ki_moist:     16'h0000,
      limit_temp:   23'h000000,
      limit_humid:  23'h000000,
      dt_limit:     16'h0001,
      gain_floor:   16'h0000,
      gain_ceiling: 16'h0000
   };
   // small limits, no dt, floor above ceiling
   localparam cfg_type PinchCfg = '{
      ki_temp:      16'd1000,
      ki_moist:     16'd1000,
      limit_temp:   23'd50000,
      limit_humid:  23'd70000,
      dt_limit:     16'd0,
      gain_floor:   16'd60000,
      gain_ceiling: 16'd2000
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_word;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_word;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   int mismatches;
   int outstanding;
   int checked;
   int cycle_count = 0;

   int words_sent     = 0;
   int clears_sent    = 0;
   int zero_steps     = 0;
   int settings_used  = 0;
   int send_gap_pct   = 0;
   bit rsp_stalls     = 1'b0;
   bit hold_rsp       = 1'b0;

   integral_gain_tuner_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gain_tuner_monitor gain_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog
   initial begin
      wait (cycle_count == CycleLimit);
      $display("FAILURE");
      $finish;
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b1;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic req_type compose_word(
      input logic               cmd,
      input logic signed [15:0] t_err,
      input logic               t_ok,
      input logic signed [15:0] h_err,
      input logic               h_ok,
      input logic [15:0]        dt_field
   );
      req_type w;
      w.cmd         = cmd;
      w.temp_error  = t_err;
      w.temp_valid  = t_ok;
      w.humid_error = h_err;
      w.humid_valid = h_ok;
      w.step_time   = dt_field;
      return w;
   endfunction

   // modest errors half the time so integrals move inside their limits
   function automatic logic signed [15:0] pick_error();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return 16'($urandom_range(0, 2047) - 1024);
         4, 5:       return 16'($urandom);
         6:          return ErrMax;
         default:    return ErrMin;
      endcase
   endfunction

   function automatic req_type make_word(input int clear_pct);
      req_type w;
      w.cmd         = ($urandom_range(1, 100) <= clear_pct) ? CmdClear : CmdUpdate;
      w.temp_error  = pick_error();
      w.temp_valid  = ($urandom_range(0, 7) != 0);
      w.humid_error = pick_error();
      w.humid_valid = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 9))
         0:          w.step_time = 16'd0;
         1, 2, 3, 4: w.step_time = 16'($urandom_range(1, 512));
         5, 6, 7:    w.step_time = 16'($urandom);
         8:          w.step_time = 16'hFFFF;
         default:    w.step_time = 16'($urandom_range(2400, 2700));
      endcase
      return w;
   endfunction

   function automatic cfg_type random_settings();
      cfg_type     c;
      logic [15:0] lo;
      logic [15:0] hi;
      c.ki_temp     = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383));
      c.ki_moist    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383));
      c.limit_temp  = ($urandom_range(0, 2) == 0) ? 23'($urandom) : 23'($urandom_range(0, 1 << 21));
      c.limit_humid = ($urandom_range(0, 2) == 0) ? 23'($urandom) : 23'($urandom_range(0, 1 << 21));
      c.dt_limit    = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
      lo = 16'($urandom);
      hi = 16'($urandom);
      if (lo > hi) begin
         {lo, hi} = {hi, lo};
      end
      // now and then an inverted gain range
      if ($urandom_range(0, 5) == 0) begin
         {lo, hi} = {hi, lo};
      end
      c.gain_floor   = lo;
      c.gain_ceiling = hi;
      return c;
   endfunction

   // offer one word, hold it until taken, then maybe idle a burst
   task automatic send_word(input req_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (w.cmd == CmdClear) begin
         clears_sent++;
      end else if (w.step_time == 16'd0) begin
         zero_steps++;
      end
      if (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // stop offering and let every outstanding result drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // full register set plus a write to the unused index
   task automatic load_cfg(input cfg_type c);
      csr_write(CSR_KI_TEMP, CsrDataW'(c.ki_temp));
      csr_write(CSR_KI_HUMID, CsrDataW'(c.ki_moist));
      csr_write(CSR_LIMIT_TEMP, c.limit_temp);
      csr_write(CSR_LIMIT_HUMID, c.limit_humid);
      csr_write(CSR_DT_LIMIT, CsrDataW'(c.dt_limit));
      csr_write(CSR_GAIN_FLOOR, CsrDataW'(c.gain_floor));
      csr_write(CSR_GAIN_CEILING, CsrDataW'(c.gain_ceiling));
      csr_write(CsrUnused, CsrDataW'($urandom));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_KI_TEMP;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: saturation both ways, zero step, frozen channels
      send_word(compose_word(CmdClear, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'd0));
      send_word(compose_word(CmdUpdate, ErrMax, 1'b1, ErrMax, 1'b1, 16'hFFFF));
      send_word(compose_word(CmdUpdate, ErrMax, 1'b1, ErrMax, 1'b1, 16'hFFFF));
      send_word(compose_word(CmdUpdate, ErrMin, 1'b1, ErrMin, 1'b1, 16'hFFFF));
      send_word(compose_word(CmdUpdate, ErrMax, 1'b1, ErrMin, 1'b1, 16'd0));
      send_word(compose_word(CmdUpdate, 16'sd900, 1'b1, 16'sd700, 1'b0, 16'd256));
      send_word(compose_word(CmdUpdate, 16'sd900, 1'b0, 16'sd700, 1'b1, 16'd256));
      send_word(compose_word(CmdUpdate, -16'sd300, 1'b0, -16'sd300, 1'b0, 16'd256));
      send_word(compose_word(CmdUpdate, 16'sd1, 1'b1, -16'sd1, 1'b1, 16'd1));
      send_word(compose_word(CmdClear, ErrMin, 1'b1, ErrMax, 1'b1, 16'hFFFF));

      // widest settings: integrators pinned at the largest limit
      settle();
      load_cfg(MaxCfg);
      send_word(compose_word(CmdUpdate, ErrMax, 1'b1, ErrMax, 1'b1, 16'hFFFF));
      send_word(compose_word(CmdUpdate, ErrMin, 1'b1, ErrMin, 1'b1, 16'hFFFF));
      send_word(compose_word(CmdUpdate, ErrMax, 1'b1, ErrMax, 1'b1, 16'hFFFF));

      // lowered limits with zero dt: clamp on next integration only
      settle();
      load_cfg(PinchCfg);
      send_word(compose_word(CmdUpdate, 16'sd500, 1'b1, 16'sd500, 1'b0, 16'd300));
      send_word(compose_word(CmdUpdate, 16'sd500, 1'b1, 16'sd500, 1'b1, 16'd0));
      send_word(compose_word(CmdUpdate, -16'sd20, 1'b1, 16'sd20, 1'b1, 16'd7));
      send_word(compose_word(CmdClear, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'd0));

      // narrowest settings
      settle();
      load_cfg(MinCfg);
      send_word(compose_word(CmdUpdate, ErrMax, 1'b1, ErrMin, 1'b1, 16'hFFFF));
      send_word(compose_word(CmdUpdate, ErrMin, 1'b1, ErrMax, 1'b1, 16'd1));
      send_word(compose_word(CmdClear, ErrMax, 1'b0, ErrMax, 1'b0, 16'd0));

      // random phases, each under its own register settings
      for (int p = 0; p < RandomPhases; p++) begin
         settle();
         case (p)
            0:       load_cfg(ResetCfg);
            4:       load_cfg(MaxCfg);
            default: load_cfg(random_settings());
         endcase
         if (p == RandomPhases - 1) begin
            send_gap_pct = 0;
            rsp_stalls   = 1'b0;
         end else begin
            case ($urandom_range(0, 2))
               0:       send_gap_pct = 0;
               1:       send_gap_pct = 15;
               default: send_gap_pct = 40;
            endcase
            rsp_stalls = ($urandom_range(0, 2) != 0);
         end
         for (int n = 0; n < WordsPerPhase; n++) begin
            if (p == HoldPhase && n == 20) begin
               hold_rsp = 1'b1;
            end
            send_word(make_word(6));
         end
      end

      settle();
      $display("Run summary: %0d words sent (%0d clears, %0d zero-step updates)",
               words_sent, clears_sent, zero_steps);
      $display("Run summary: %0d register settings, %0d gain words checked, %0d mismatches.",
               settings_used, checked, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
